@@ src/led_blink_code_sequencer_defines.svh @@
// Assertion macros for the LED blink-code sequencer.
// Included by the top level; no other dependencies.
// In synthesis the macros expand to nothing.
`ifndef LED_BLINK_CODE_SEQUENCER_DEFINES_SVH
`define LED_BLINK_CODE_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted
`define LBCS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define LBCS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define LBCS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LBCS_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ src/lbcs_pkg.sv @@
// Shared types and constants for the LED blink-code sequencer.
// No dependencies; used by the top level.
package lbcs_pkg;

  localparam int unsigned LED_COUNT     = 8;
  localparam int unsigned ELAPSED_W     = 17;
  localparam int unsigned DELAY_W       = 16;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
  localparam logic [DELAY_W-1:0]   DELAY_RESET = 16'd250;

  typedef enum logic {
    OP_TICK    = 1'b0,
    OP_ENQUEUE = 1'b1
  } opcode_t;

  // One queued blink request as held in the request memory
  typedef struct packed {
    logic [2:0] led;
    logic [3:0] blinks;
    logic [3:0] rounds;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

@@ src/lbcs_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; holds the request queue of the sequencer.
module lbcs_ram #(
  parameter int unsigned WIDTH = 11,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, then registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/led_blink_code_sequencer.sv @@
// Top level of the LED blink-code sequencer.
// Depends on lbcs_pkg, lbcs_ram and led_blink_code_sequencer_defines.svh.
//
// Usage:
//   Input channel: drive in_opcode and the request fields with start high;
//   the item is taken at a rising edge where start is high and busy low.
//   A tick (opcode 0) advances the blink player; an enqueue (opcode 1)
//   appends a request to the queue memory, or flags it dropped when full.
//   Result channel: exactly one result per item, shown for one cycle with
//   out_valid high. The receiver cannot stall; results are not held.
//   Latency: the transfer edge reads the queue head from the memory, the
//   next edge performs the read-modify-write of the player state and the
//   queue, and the result is on the ports in the cycle after that.
//   Pacing: no new item is taken while one is in flight; busy is high
//   during the update step that follows the queue memory read.
//   Configuration: cfg_wr_en with cfg_wr_data writes the toggle gap at once;
//   write it only while no item is in flight.
//   Reset (rst_n low, synchronous): empty queue, nothing playing, LED off,
//   toggle gap back to 250. Queue entries are not cleared; only written
//   entries are ever used.
module led_blink_code_sequencer
  import lbcs_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  // input channel
  input  logic         start,
  output logic         busy,
  input  logic         in_opcode,
  input  logic [2:0]   in_led_select,
  input  logic [3:0]   in_blink_count,
  input  logic [3:0]   in_repeat_count,
  // result channel
  output logic         out_valid,
  output logic         out_led_update,
  output logic [2:0]   out_led_index,
  output logic         out_led_level,
  output logic         out_dropped,
  output logic         out_busy_res,
  // configuration
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data
);

`include "led_blink_code_sequencer_defines.svh"

  localparam int unsigned PTR_W  = $clog2(FIFO_DEPTH);
  localparam int unsigned FILL_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [PTR_W-1:0]  PTR_LAST   = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_FULL  = FILL_W'(FIFO_DEPTH);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state_r;

  // Player and queue control state
  logic [PTR_W-1:0]     head_r, head_nxt;
  logic [PTR_W-1:0]     tail_r, tail_nxt;
  logic [FILL_W-1:0]    fill_r, fill_nxt;
  logic                 playing_r, playing_nxt;
  logic                 counting_r, counting_nxt;
  logic                 led_on_r, led_on_nxt;
  logic [2:0]           active_led_r, active_led_nxt;
  logic [4:0]           blinks_left_r, blinks_left_nxt;
  logic [3:0]           rounds_left_r, rounds_left_nxt;
  logic [3:0]           orig_blinks_r, orig_blinks_nxt;
  logic [ELAPSED_W-1:0] elapsed_r, elapsed_nxt;
  logic [DELAY_W-1:0]   toggle_gap_r;

  // Captured input item
  opcode_t    opcode_r;
  logic [2:0] sel_r;
  logic [3:0] cnt_r;
  logic [3:0] rep_r;

  // Registered result
  logic       out_valid_r;
  logic       out_update_r;
  logic [2:0] out_index_r;
  logic       out_level_r;
  logic       out_dropped_r;
  logic       out_busy_r;

  // Update-step signals
  logic       accept;
  logic       pop;
  logic       push;
  logic       push_ok;
  logic       fifo_full;
  entry_t     push_entry;
  entry_t     head_entry;
  logic [ENTRY_W-1:0] rd_data;
  logic       upd;
  logic [2:0] upd_index;
  logic       upd_level;

  assign accept     = start && !busy;
  assign busy       = (state_r == ST_EXEC);
  assign head_entry = entry_t'(rd_data);
  assign fifo_full  = (fill_r == FILL_FULL);
  assign push_ok    = push && !fifo_full;

  // Request queue storage; head is read on the transfer edge
  lbcs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (FIFO_DEPTH)
  ) u_queue (
    .clk   (clk),
    .we    (push_ok),
    .waddr (tail_r),
    .wdata (push_entry),
    .re    (accept),
    .raddr (head_r),
    .rdata (rd_data)
  );

  // Capture the input item
  always_ff @(posedge clk) begin
    if (accept) begin
      opcode_r <= opcode_t'(in_opcode);
      sel_r    <= in_led_select;
      cnt_r    <= in_blink_count;
      rep_r    <= in_repeat_count;
    end
  end

  // Read-modify-write of the player state for one item
  always_comb begin
    playing_nxt     = playing_r;
    counting_nxt    = counting_r;
    led_on_nxt      = led_on_r;
    active_led_nxt  = active_led_r;
    blinks_left_nxt = blinks_left_r;
    rounds_left_nxt = rounds_left_r;
    orig_blinks_nxt = orig_blinks_r;
    elapsed_nxt     = elapsed_r;
    pop             = 1'b0;
    push            = 1'b0;
    push_entry      = '0;
    upd             = 1'b0;
    upd_index       = '0;
    upd_level       = 1'b0;

    if (state_r == ST_EXEC) begin
      if (opcode_r == OP_ENQUEUE) begin
        // enqueue: LEDs beyond the fitted count are ignored
        if (32'(sel_r) < LED_COUNT) begin
          push       = 1'b1;
          push_entry = '{led: sel_r, blinks: cnt_r, rounds: rep_r};
        end
      end else begin
        // start the head request when nothing plays
        if (!playing_r && (fill_r != '0)) begin
          pop             = 1'b1;
          active_led_nxt  = head_entry.led;
          orig_blinks_nxt = head_entry.blinks;
          blinks_left_nxt = (head_entry.blinks == '0) ? 5'd1 : {1'b0, head_entry.blinks};
          rounds_left_nxt = head_entry.rounds;
          led_on_nxt      = 1'b0;
          counting_nxt    = 1'b1;
          elapsed_nxt     = ELAPSED_MAX;
          playing_nxt     = 1'b1;
        end
        if (playing_nxt) begin
          if (elapsed_nxt != ELAPSED_MAX) begin
            elapsed_nxt = elapsed_nxt + 1'b1;
          end
          if (counting_nxt) begin
            // toggle once the delay has passed; an off edge ends one blink
            if (elapsed_nxt > {1'b0, toggle_gap_r}) begin
              elapsed_nxt = '0;
              led_on_nxt  = !led_on_nxt;
              upd         = 1'b1;
              upd_index   = active_led_nxt;
              upd_level   = led_on_nxt;
              if (!led_on_nxt) begin
                if (blinks_left_nxt != '0) begin
                  blinks_left_nxt = blinks_left_nxt - 1'b1;
                end
                if (blinks_left_nxt == '0) begin
                  counting_nxt = 1'b0;
                end
              end
            end
          end else if (elapsed_nxt > {toggle_gap_r, 1'b0}) begin
            // gap over: re-queue unless the last round is done
            if (rounds_left_nxt != '0) begin
              rounds_left_nxt = rounds_left_nxt - 1'b1;
              if (rounds_left_nxt != '0) begin
                push       = 1'b1;
                push_entry = '{led: active_led_nxt, blinks: orig_blinks_nxt,
                               rounds: rounds_left_nxt};
              end
            end else begin
              push       = 1'b1;
              push_entry = '{led: active_led_nxt, blinks: orig_blinks_nxt, rounds: 4'd0};
            end
            playing_nxt = 1'b0;
          end
        end
      end
    end

    // Queue pointers and fill count
    head_nxt = head_r;
    tail_nxt = tail_r;
    fill_nxt = fill_r;
    if (pop) begin
      head_nxt = (head_r == PTR_LAST) ? '0 : head_r + 1'b1;
      fill_nxt = fill_nxt - 1'b1;
    end
    if (push && !fifo_full) begin
      tail_nxt = (tail_r == PTR_LAST) ? '0 : tail_r + 1'b1;
      fill_nxt = fill_nxt + 1'b1;
    end
  end

  // State machine, player state and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      head_r        <= '0;
      tail_r        <= '0;
      fill_r        <= '0;
      playing_r     <= 1'b0;
      counting_r    <= 1'b0;
      led_on_r      <= 1'b0;
      active_led_r  <= '0;
      blinks_left_r <= '0;
      rounds_left_r <= '0;
      orig_blinks_r <= '0;
      elapsed_r     <= ELAPSED_MAX;
      toggle_gap_r  <= DELAY_RESET;
      out_valid_r   <= 1'b0;
      out_update_r  <= 1'b0;
      out_index_r   <= '0;
      out_level_r   <= 1'b0;
      out_dropped_r <= 1'b0;
      out_busy_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        toggle_gap_r <= cfg_wr_data;
      end
      out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state_r       <= ST_IDLE;
          head_r        <= head_nxt;
          tail_r        <= tail_nxt;
          fill_r        <= fill_nxt;
          playing_r     <= playing_nxt;
          counting_r    <= counting_nxt;
          led_on_r      <= led_on_nxt;
          active_led_r  <= active_led_nxt;
          blinks_left_r <= blinks_left_nxt;
          rounds_left_r <= rounds_left_nxt;
          orig_blinks_r <= orig_blinks_nxt;
          elapsed_r     <= elapsed_nxt;
          out_valid_r   <= 1'b1;
          out_update_r  <= upd;
          out_index_r   <= upd_index;
          out_level_r   <= upd_level;
          out_dropped_r <= push && fifo_full;
          out_busy_r    <= playing_nxt || (fill_nxt != '0);
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_led_update = out_update_r;
  assign out_led_index  = out_index_r;
  assign out_led_level  = out_level_r;
  assign out_dropped    = out_dropped_r;
  assign out_busy_res   = out_busy_r;

  // Checks on queue bookkeeping and result consistency
  `LBCS_ASSERT_IMP(a_fill_bound, clk, rst_n, 1'b1, fill_r <= FILL_FULL)
  `LBCS_ASSERT_NXT(a_exec_gives_result, clk, rst_n, state_r == ST_EXEC, out_valid_r)
  `LBCS_ASSERT_IMP(a_update_while_playing, clk, rst_n, out_valid_r && out_update_r, playing_r)
  `LBCS_ASSERT_IMP(a_busy_res_matches, clk, rst_n, out_valid_r,
                   out_busy_r == (playing_r || (fill_r != '0)))

endmodule
